// File: src/ptc_pkg.sv
// ptc_pkg: widths, register map and pipeline constants for the
// pressure/temperature compensation block. No dependencies.
package ptc_pkg;

	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 32;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int LATENCY = 10;

	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

endpackage

// File: src/pressure_temp_compensation.sv
// pressure_temp_compensation: ten-stage pipelined second-order compensation
// of raw pressure/temperature conversions, with APB calibration registers.
// Depends on ptc_pkg.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------
//  input    | start & !busy                 | raw_pressure, raw_temperature
//  result   | done (one cycle)              | temperature, pressure
//  config   | psel & penable & pwrite       | paddr, pwdata (prdata on read)
//
// One transfer per cycle; busy is always low. Each result is presented on done
// once its input transfer has passed through the ten register stages (products of dT,
// squares, band terms, split D1*SENS2 product, scaling).
// Reset clears the calibration words and the stage valid bits.
// The receiver cannot stall, so nothing holds the pipeline.
module pressure_temp_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ptc_pkg::RAW_W-1:0]      raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]      raw_temperature,
	output logic                           done,
	output logic signed [ptc_pkg::TEMP_W-1:0] temperature,
	output logic signed [ptc_pkg::PRES_W-1:0] pressure,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0]     paddr,
	input  logic [ptc_pkg::DATA_W-1:0]     pwdata,
	output logic [ptc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import ptc_pkg::*;

	localparam logic signed [41:0] RND23 = 42'sd8388607;
	localparam logic signed [41:0] RND7  = 42'sd127;
	localparam logic signed [41:0] RND8  = 42'sd255;
	localparam logic signed [65:0] RND21 = 66'sd2097151;
	localparam logic signed [45:0] RND13 = 46'sd8191;
	localparam logic signed [19:0] T_REF = 20'sd2000;
	localparam logic signed [19:0] T_LOW = 20'sd1500;
	localparam logic signed [45:0] P_MAX = 46'sd2147483647;
	localparam logic signed [45:0] P_MIN = -46'sd2147483648;

	// calibration words
	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	reg_idx_t         reg_idx;
	logic             wr_en;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_C1: c1_q <= pwdata[CAL_W-1:0];
				REG_C2: c2_q <= pwdata[CAL_W-1:0];
				REG_C3: c3_q <= pwdata[CAL_W-1:0];
				REG_C4: c4_q <= pwdata[CAL_W-1:0];
				REG_C5: c5_q <= pwdata[CAL_W-1:0];
				REG_C6: c6_q <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_C1: prdata = {{(DATA_W-CAL_W){1'b0}}, c1_q};
			REG_C2: prdata = {{(DATA_W-CAL_W){1'b0}}, c2_q};
			REG_C3: prdata = {{(DATA_W-CAL_W){1'b0}}, c3_q};
			REG_C4: prdata = {{(DATA_W-CAL_W){1'b0}}, c4_q};
			REG_C5: prdata = {{(DATA_W-CAL_W){1'b0}}, c5_q};
			REG_C6: prdata = {{(DATA_W-CAL_W){1'b0}}, c6_q};
			default: prdata = '0;
		endcase
	end

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// stage 1: dT
	logic [RAW_W-1:0]   d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		d1_s1 <= raw_pressure;
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'h00});
	end

	// stage 2: products of dT
	logic [RAW_W-1:0]   d1_s2;
	logic signed [41:0] ptc_s2, poff_s2, psens_s2;
	logic [47:0]        dtsq_s2;
	logic signed [49:0] dtsq_c;

	assign dtsq_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		d1_s2    <= d1_s1;
		ptc_s2   <= dt_s1 * $signed({1'b0, c6_q});
		poff_s2  <= dt_s1 * $signed({1'b0, c4_q});
		psens_s2 <= dt_s1 * $signed({1'b0, c3_q});
		dtsq_s2  <= dtsq_c[47:0];
	end

	// stage 3: TEMP, OFF, SENS (truncating shifts)
	logic [RAW_W-1:0]   d1_s3;
	logic signed [19:0] temp_s3;
	logic signed [39:0] off_s3, sens_s3;
	logic [47:0]        dtsq_s3;
	logic signed [41:0] tc_q, off_qt, sens_qt;

	assign tc_q    = (ptc_s2 + (ptc_s2[41] ? RND23 : 42'sd0)) >>> 23;
	assign off_qt  = (poff_s2 + (poff_s2[41] ? RND7 : 42'sd0)) >>> 7;
	assign sens_qt = (psens_s2 + (psens_s2[41] ? RND8 : 42'sd0)) >>> 8;

	always_ff @(posedge clk) begin
		d1_s3   <= d1_s2;
		temp_s3 <= T_REF + tc_q[19:0];
		off_s3  <= $signed({8'h00, c2_q, 16'h0000}) + off_qt[39:0];
		sens_s3 <= $signed({9'h000, c1_q, 15'h0000}) + sens_qt[39:0];
		dtsq_s3 <= dtsq_s2;
	end

	// stage 4: bands, Ti, squares of deviations
	logic [RAW_W-1:0]   d1_s4;
	logic signed [19:0] temp2_s4;
	logic signed [39:0] off_s4, sens_s4;
	logic               lo_s4, vlo_s4;
	logic [35:0]        dev2_s4, low2_s4;
	logic               lo_c;
	logic [49:0]        ti3_c;
	logic [16:0]        ti_c;
	logic signed [19:0] dev_c, low_c;
	logic signed [39:0] dev2_c, low2_c;

	assign lo_c   = temp_s3 < T_REF;
	assign ti3_c  = {1'b0, dtsq_s3, 1'b0} + {2'b00, dtsq_s3};
	assign ti_c   = lo_c ? ti3_c[49:33] : {5'b0_0000, dtsq_s3[47:36]};
	assign dev_c  = temp_s3 - T_REF;
	assign low_c  = temp_s3 + T_LOW;
	assign dev2_c = dev_c * dev_c;
	assign low2_c = low_c * low_c;

	always_ff @(posedge clk) begin
		d1_s4    <= d1_s3;
		temp2_s4 <= temp_s3 - $signed({3'b000, ti_c});
		off_s4   <= off_s3;
		sens_s4  <= sens_s3;
		lo_s4    <= lo_c;
		vlo_s4   <= temp_s3 < -T_LOW;
		dev2_s4  <= dev2_c[35:0];
		low2_s4  <= low2_c[35:0];
	end

	// stage 5: OFFi, SENSi
	logic [RAW_W-1:0]   d1_s5;
	logic signed [19:0] temp2_s5;
	logic signed [39:0] off_s5, sens_s5;
	logic               lo_s5;
	logic [39:0]        offi_s5, sensi_s5;
	logic [39:0]        dev2_w, low2_w, offi_c, sensi_c, off3_c, sens5_c;

	assign dev2_w  = {4'h0, dev2_s4};
	assign low2_w  = {4'h0, low2_s4};
	assign off3_c  = (dev2_w << 1) + dev2_w;
	assign sens5_c = (dev2_w << 2) + dev2_w;

	always_comb begin
		if (lo_s4) begin
			offi_c  = (off3_c >> 1) + (vlo_s4 ? ((low2_w << 3) - low2_w) : 40'd0);
			sensi_c = (sens5_c >> 3) + (vlo_s4 ? (low2_w << 2) : 40'd0);
		end else begin
			offi_c  = dev2_w >> 4;
			sensi_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		d1_s5    <= d1_s4;
		temp2_s5 <= temp2_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		lo_s5    <= lo_s4;
		offi_s5  <= offi_c;
		sensi_s5 <= sensi_c;
	end

	// stage 6: OFF2, SENS2
	logic [RAW_W-1:0]   d1_s6;
	logic signed [19:0] temp2_s6;
	logic signed [39:0] off2_s6, sens2_s6;

	always_ff @(posedge clk) begin
		d1_s6    <= d1_s5;
		temp2_s6 <= temp2_s5;
		off2_s6  <= off_s5 - $signed({1'b0, offi_s5[38:0]});
		sens2_s6 <= sens_s5 - $signed({1'b0, sensi_s5[38:0]});
	end

	// stage 7: D1*SENS2 as two partial products
	logic signed [19:0] temp2_s7;
	logic signed [39:0] off2_s7;
	logic [43:0]        pl_s7;
	logic signed [44:0] ph_s7;

	always_ff @(posedge clk) begin
		temp2_s7 <= temp2_s6;
		off2_s7  <= off2_s6;
		pl_s7    <= {20'h00000, d1_s6} * {24'h000000, sens2_s6[19:0]};
		ph_s7    <= $signed({1'b0, d1_s6}) * $signed(sens2_s6[39:20]);
	end

	// stage 8: recombine
	logic signed [19:0] temp2_s8;
	logic signed [39:0] off2_s8;
	logic signed [65:0] prod_s8;

	always_ff @(posedge clk) begin
		temp2_s8 <= temp2_s7;
		off2_s8  <= off2_s7;
		prod_s8  <= $signed({ph_s7[44], ph_s7, 20'h00000}) + $signed({22'h000000, pl_s7});
	end

	// stage 9: /2^21 - OFF2
	logic signed [19:0] temp2_s9;
	logic signed [45:0] x_s9;
	logic signed [65:0] prod_q;

	assign prod_q = (prod_s8 + (prod_s8[65] ? RND21 : 66'sd0)) >>> 21;

	always_ff @(posedge clk) begin
		temp2_s9 <= temp2_s8;
		x_s9     <= prod_q[45:0] - {{6{off2_s8[39]}}, off2_s8};
	end

	// stage 10: /2^13, saturate
	logic signed [TEMP_W-1:0] temp_s10;
	logic signed [PRES_W-1:0] pres_s10;
	logic signed [45:0]       y_c;

	assign y_c = (x_s9 + (x_s9[45] ? RND13 : 46'sd0)) >>> 13;

	always_ff @(posedge clk) begin
		temp_s10 <= temp2_s9[TEMP_W-1:0];
		if (y_c > P_MAX) begin
			pres_s10 <= P_MAX[PRES_W-1:0];
		end else if (y_c < P_MIN) begin
			pres_s10 <= P_MIN[PRES_W-1:0];
		end else begin
			pres_s10 <= y_c[PRES_W-1:0];
		end
	end

	assign done        = valid_s10;
	assign temperature = temp_s10;
	assign pressure    = pres_s10;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching input transfer");

	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("input transfer lost in pipeline");

	a_bands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && vlo_s4 |-> lo_s4)
		else $error("cold band outside low band");

	a_sensi: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !lo_s5 |-> sensi_s5 == 40'd0)
		else $error("sensitivity correction in warm band");

endmodule
